// ===== rtl/cba_pkg.sv =====
// Shared types and constants of the contiguous block allocator.
package cba_pkg;

	// Default sizing of the block map
	localparam int NUM_BLOCKS_DEF  = 256;
	localparam int BLOCK_BYTES_DEF = 65536;

	// Field and register widths
	localparam int BYTES_W   = 25;
	localparam int FIDX_W    = 8;
	localparam int ADDR_W    = 40;
	localparam int REGION_W  = 9;
	localparam int BB_W      = 21;
	localparam int REG_IDX_W = 1;

	// Configuration register indexes and reset values
	localparam logic [REG_IDX_W-1:0] REG_REGION = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_BASE   = 1'd1;
	localparam logic [REGION_W-1:0]  REGION_RST = 9'd256;

	// Request types on the input
	localparam logic REQ_ALLOC = 1'b0;

	// Result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_BADIDX  = 2'd2;

	// Request queue depth between front and back
	localparam int QDEPTH = 2;

	// Classified operation handed to the back end
	typedef enum logic [1:0] {
		OP_ALLOC,
		OP_FREE,
		OP_NOSPACE,
		OP_BADIDX
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [BYTES_W-1:0] bytes;
		logic [FIDX_W-1:0]  idx;
	} req_t;

	// Queue head seen by the back end
	typedef struct packed {
		logic valid;
		req_t req;
	} fq_head_t;

	// Back end status returned to the front
	typedef struct packed {
		logic clearing;
		logic pop;
	} bk_stat_t;

endpackage

// ===== rtl/contiguous_block_allocator.sv =====
// Top level of the first-fit contiguous block allocator.
//
// Requests are taken when start is high and busy is low; each request gives
// exactly one result, in request order, shown for one cycle with done high.
// The receiver cannot stall results. After reset the block map is cleared in
// one pass with busy held high; configuration writes are taken during it. A
// two-entry queue buffers requests ahead of the map engine, so once the map is
// cleared busy drops whenever the queue has room. An allocate scans the map one
// block per cycle from index zero, up to the usable region size. Zero-byte
// allocates and free indexes beyond the map answer without a map access. The
// map memory has one registered read and one write per cycle.
module contiguous_block_allocator import cba_pkg::*; #(
	parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
	parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 req_type,
	input  logic [BYTES_W-1:0]   request_bytes,
	input  logic [FIDX_W-1:0]    free_index,
	output logic                 done,
	output logic [1:0]           status,
	output logic [FIDX_W-1:0]    first_block,
	output logic [ADDR_W-1:0]    phys_address,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_wdata
);

	logic [REGION_W-1:0] region_blocks_q;
	logic [ADDR_W-1:0]   base_address_q;
	fq_head_t            head;
	bk_stat_t            stat;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_blocks_q <= REGION_RST;
			base_address_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_REGION: region_blocks_q <= cfg_wdata[REGION_W-1:0];
				REG_BASE:   base_address_q  <= cfg_wdata;
				default:    region_blocks_q <= region_blocks_q;
			endcase
		end
	end

	cba_front #(
		.NUM_BLOCKS(NUM_BLOCKS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.req_type      (req_type),
		.request_bytes (request_bytes),
		.free_index    (free_index),
		.stat          (stat),
		.busy          (busy),
		.head          (head)
	);

	cba_back #(
		.NUM_BLOCKS  (NUM_BLOCKS),
		.BLOCK_BYTES (BLOCK_BYTES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.region_blocks (region_blocks_q),
		.base_address  (base_address_q),
		.stat          (stat),
		.done          (done),
		.status        (status),
		.first_block   (first_block),
		.phys_address  (phys_address)
	);

endmodule

// ===== rtl/cba_front.sv =====
// Front end: request intake, classification and request queue.
module cba_front import cba_pkg::*; #(
	parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                req_type,
	input  logic [BYTES_W-1:0]  request_bytes,
	input  logic [FIDX_W-1:0]   free_index,
	input  bk_stat_t            stat,
	output logic                busy,
	output fq_head_t            head
);

	localparam int QP_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QC_W = $clog2(QDEPTH + 1);

	req_t              q_mem_q [QDEPTH];
	logic [QP_W-1:0]   wr_ptr_q;
	logic [QP_W-1:0]   rd_ptr_q;
	logic [QC_W-1:0]   fill_q;
	logic              accept;
	req_t              req_new;

	// Classify the incoming request
	always_comb begin
		req_new.bytes = request_bytes;
		req_new.idx   = free_index;
		if (req_type == REQ_ALLOC) begin
			req_new.op = (request_bytes == '0) ? OP_NOSPACE : OP_ALLOC;
		end else begin
			req_new.op = (32'(free_index) >= 32'(NUM_BLOCKS)) ? OP_BADIDX : OP_FREE;
		end
	end

	// Hold off intake while the queue is full or the map is being cleared
	assign busy   = (fill_q == QC_W'(QDEPTH)) || stat.clearing;
	assign accept = start && !busy;

	assign head.valid = (fill_q != '0);
	assign head.req   = q_mem_q[rd_ptr_q];

	// Store accepted requests
	always_ff @(posedge clk) begin
		if (accept) begin
			q_mem_q[wr_ptr_q] <= req_new;
		end
	end

	// Advance queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= (wr_ptr_q == QP_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QP_W'(1);
			end
			if (stat.pop) begin
				rd_ptr_q <= (rd_ptr_q == QP_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QP_W'(1);
			end
			case ({accept, stat.pop})
				2'b10:   fill_q <= fill_q + QC_W'(1);
				2'b01:   fill_q <= fill_q - QC_W'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

	ap_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= QC_W'(QDEPTH))
		else $error("request queue overfilled");

	ap_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		stat.pop |-> (fill_q != '0))
		else $error("pop from empty request queue");

	ap_accept_visible: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> head.valid)
		else $error("accepted request not visible at queue head");

endmodule

// ===== rtl/cba_back.sv =====
// Back end: block map memory, first-fit scan, run marking and freeing.
module cba_back import cba_pkg::*; #(
	parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
	parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fq_head_t            head,
	input  logic [REGION_W-1:0] region_blocks,
	input  logic [ADDR_W-1:0]   base_address,
	output bk_stat_t            stat,
	output logic                done,
	output logic [1:0]          status,
	output logic [FIDX_W-1:0]   first_block,
	output logic [ADDR_W-1:0]   phys_address
);

	localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
	localparam int LIM_W = (CNT_W > REGION_W) ? CNT_W : REGION_W;
	localparam int PW    = IDX_W + BB_W;
	localparam int RUN_W = BYTES_W + 1;

	localparam logic [1:0] MK_EMPTY = 2'd0;
	localparam logic [1:0] MK_BEGIN = 2'd1;
	localparam logic [1:0] MK_CONT  = 2'd2;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_ASCAN,
		S_AMARK,
		S_MUL,
		S_ADD,
		S_FREAD,
		S_FCHECK,
		S_FSCAN
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [IDX_W-1:0]    ev_q;
	logic                vld_q;
	logic [BYTES_W-1:0]  run_q;
	logic [BYTES_W-1:0]  bytes_q;
	logic [IDX_W-1:0]    start_q;
	logic [IDX_W-1:0]    end_q;
	logic [IDX_W-1:0]    idx_q;
	logic [PW-1:0]       prod_s1;
	logic                done_q;
	logic [1:0]          status_q;
	logic [FIDX_W-1:0]   fb_q;
	logic [ADDR_W-1:0]   addr_q;

	logic [1:0]          marks_mem [NUM_BLOCKS];
	logic [1:0]          rdata_q;
	logic                mem_we;
	logic [IDX_W-1:0]    mem_waddr;
	logic [1:0]          mem_wdata;
	logic [IDX_W-1:0]    mem_raddr;

	logic [LIM_W-1:0]    region_lim;
	logic [LIM_W-1:0]    scan_lim;
	logic                issue;
	logic [RUN_W-1:0]    run_sum;
	logic                fit;
	logic [IDX_W-1:0]    run_first;

	// Usable region is the smaller of the register and the map size
	assign region_lim = (LIM_W'(region_blocks) > LIM_W'(NUM_BLOCKS)) ?
		LIM_W'(NUM_BLOCKS) : LIM_W'(region_blocks);
	assign scan_lim  = (state_q == S_ASCAN) ? region_lim : LIM_W'(NUM_BLOCKS);
	assign issue     = LIM_W'(cnt_q) < scan_lim;

	// Run length tracked in bytes, so no block-count division is needed
	assign run_sum   = RUN_W'(run_q) + RUN_W'(BLOCK_BYTES);
	assign fit       = run_sum >= RUN_W'(bytes_q);
	assign run_first = (run_q == '0) ? ev_q : start_q;

	assign stat.clearing = (state_q == S_CLEAR);
	assign stat.pop      = (state_q == S_IDLE) && head.valid;

	assign done         = done_q;
	assign status       = status_q;
	assign first_block  = fb_q;
	assign phys_address = addr_q;

	// Drive the map memory ports
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q[IDX_W-1:0];
		mem_wdata = MK_EMPTY;
		mem_raddr = cnt_q[IDX_W-1:0];
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
			end
			S_FREAD: begin
				mem_raddr = idx_q;
			end
			S_FCHECK: begin
				mem_we    = (rdata_q == MK_BEGIN);
				mem_waddr = idx_q;
			end
			S_FSCAN: begin
				mem_we    = vld_q && (rdata_q == MK_CONT);
				mem_waddr = ev_q;
			end
			S_AMARK: begin
				mem_we    = 1'b1;
				mem_wdata = (cnt_q[IDX_W-1:0] == start_q) ? MK_BEGIN : MK_CONT;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Block map with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			marks_mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= marks_mem[mem_raddr];
	end

	// Sequence clearing, allocation and freeing; register results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			cnt_q    <= '0;
			ev_q     <= '0;
			vld_q    <= 1'b0;
			run_q    <= '0;
			bytes_q  <= '0;
			start_q  <= '0;
			end_q    <= '0;
			idx_q    <= '0;
			prod_s1  <= '0;
			done_q   <= 1'b0;
			status_q <= ST_OK;
			fb_q     <= '0;
			addr_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					if (cnt_q == CNT_W'(NUM_BLOCKS - 1)) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_IDLE: begin
					if (head.valid) begin
						case (head.req.op)
							OP_ALLOC: begin
								bytes_q <= head.req.bytes;
								cnt_q   <= '0;
								vld_q   <= 1'b0;
								run_q   <= '0;
								state_q <= S_ASCAN;
							end
							OP_FREE: begin
								idx_q   <= IDX_W'(head.req.idx);
								state_q <= S_FREAD;
							end
							OP_NOSPACE: begin
								done_q   <= 1'b1;
								status_q <= ST_NOSPACE;
								fb_q     <= '0;
								addr_q   <= '0;
							end
							OP_BADIDX: begin
								done_q   <= 1'b1;
								status_q <= ST_BADIDX;
								fb_q     <= '0;
								addr_q   <= '0;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_ASCAN: begin
					// Issue the next read while judging the previous entry
					if (issue) begin
						cnt_q <= cnt_q + CNT_W'(1);
						ev_q  <= cnt_q[IDX_W-1:0];
						vld_q <= 1'b1;
					end else begin
						vld_q <= 1'b0;
					end
					if (vld_q) begin
						if (rdata_q == MK_EMPTY) begin
							start_q <= run_first;
							if (fit) begin
								end_q   <= ev_q;
								cnt_q   <= CNT_W'(run_first);
								state_q <= S_AMARK;
							end else begin
								run_q <= BYTES_W'(run_sum);
							end
						end else begin
							run_q <= '0;
						end
					end else if (!issue) begin
						done_q   <= 1'b1;
						status_q <= ST_NOSPACE;
						fb_q     <= '0;
						addr_q   <= '0;
						state_q  <= S_IDLE;
					end
				end
				S_AMARK: begin
					if (cnt_q[IDX_W-1:0] == end_q) begin
						state_q <= S_MUL;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_MUL: begin
					prod_s1 <= PW'(start_q) * PW'(BLOCK_BYTES);
					state_q <= S_ADD;
				end
				S_ADD: begin
					done_q   <= 1'b1;
					status_q <= ST_OK;
					fb_q     <= FIDX_W'(start_q);
					addr_q   <= base_address + ADDR_W'(prod_s1);
					state_q  <= S_IDLE;
				end
				S_FREAD: begin
					state_q <= S_FCHECK;
				end
				S_FCHECK: begin
					if (rdata_q != MK_BEGIN) begin
						done_q   <= 1'b1;
						status_q <= ST_BADIDX;
						fb_q     <= '0;
						addr_q   <= '0;
						state_q  <= S_IDLE;
					end else begin
						cnt_q   <= CNT_W'(idx_q) + CNT_W'(1);
						vld_q   <= 1'b0;
						state_q <= S_FSCAN;
					end
				end
				S_FSCAN: begin
					if (issue) begin
						cnt_q <= cnt_q + CNT_W'(1);
						ev_q  <= cnt_q[IDX_W-1:0];
						vld_q <= 1'b1;
					end else begin
						vld_q <= 1'b0;
					end
					// Stop at the first block that is not a continuation, or at the end of the map
					if ((vld_q && (rdata_q != MK_CONT)) || (!vld_q && !issue)) begin
						done_q   <= 1'b1;
						status_q <= ST_OK;
						fb_q     <= '0;
						addr_q   <= '0;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	ap_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (status_q != ST_OK)) |-> ((fb_q == '0) && (addr_q == '0)))
		else $error("failed request returned nonzero block or address");

	ap_mark_region: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_AMARK) |-> (LIM_W'(cnt_q) < region_lim))
		else $error("run marked outside usable region");

	ap_free_after_head: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_FSCAN) && vld_q) |-> (ev_q > idx_q))
		else $error("free scan reached at or before the begin block");

endmodule
